@@ rtl/core/htet_pkg.sv @@
// htet_pkg: shared types, constants and lookup functions of the tag tokenizer
// depends on nothing; used by every other file of the block but htet_ram
`timescale 1ns / 1ps

package htet_pkg;

  localparam int NAME_DEPTH = 32;
  localparam int ADDR_W     = $clog2(NAME_DEPTH);
  localparam int CNT_W      = $clog2(NAME_DEPTH + 1);
  localparam int LEN_W      = 6;
  localparam int KIND_W     = 3;
  localparam int BYTE_W     = 8;

  // void element names, packed back to back
  localparam int VOID_NUM   = 15;
  localparam int VOID_CHARS = 61;
  localparam int VOID_MAX   = 6;
  localparam int POS_W      = 3;
  localparam logic [VOID_CHARS*8-1:0] VOID_TEXT =
    "areabasebrcolembedhrimginputkeygenlinkmetaparamsourcetrackwbr";
  localparam int VOID_LEN [VOID_NUM] = '{4, 4, 2, 3, 5, 2, 3, 5, 6, 4, 4, 5, 6, 5, 3};
  localparam int VOID_OFF [VOID_NUM] =
    '{0, 4, 8, 10, 13, 18, 20, 23, 28, 34, 38, 42, 47, 53, 58};

  typedef enum logic [3:0] {
    CL_LT     = 4'd0,
    CL_BANG   = 4'd1,
    CL_DASH   = 4'd2,
    CL_SLASH  = 4'd3,
    CL_GT     = 4'd4,
    CL_ALNUM  = 4'd5,
    CL_SPACE  = 4'd6,
    CL_LF     = 4'd7,
    CL_QUOTE  = 4'd8,
    CL_OTHER  = 4'd9
  } cls_t;

  typedef enum logic [3:0] {
    SC_IDLE       = 4'd0,
    SC_LT         = 4'd1,
    SC_BANG       = 4'd2,
    SC_CMT        = 4'd3,
    SC_CMT_DASH   = 4'd4,
    SC_CMT_DASH2  = 4'd5,
    SC_OPEN_NAME  = 4'd6,
    SC_ATTR       = 4'd7,
    SC_SLASH      = 4'd8,
    SC_CLOSE_NAME = 4'd9,
    SC_END        = 4'd10
  } scan_t;

  typedef enum logic [KIND_W-1:0] {
    EV_CMT_START = 3'd0,
    EV_CMT_END   = 3'd1,
    EV_OPEN      = 3'd2,
    EV_CLOSE     = 3'd3,
    EV_SELF      = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    C_IDLE = 2'd0,
    C_READ = 2'd1,
    C_EMIT = 2'd2
  } ctl_t;

  typedef struct packed {
    logic step;     // input item taken this cycle
    logic advance;  // result taken, move to the next name character
  } htet_cmd_t;

  typedef struct packed {
    logic ev_single;  // accepted byte ends in a one-result event
    logic ev_stream;  // accepted byte ends in a named event to stream out
    logic last;       // result on show is the final one of its event
  } htet_stat_t;

  function automatic cls_t byte_class(logic [7:0] b);
    cls_t c;
    if (b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) begin
      c = CL_ALNUM;
    end else begin
      case (b)
        8'h3C: c = CL_LT;
        8'h21: c = CL_BANG;
        8'h2D: c = CL_DASH;
        8'h2F: c = CL_SLASH;
        8'h3E: c = CL_GT;
        8'h20, 8'h09, 8'h0D, 8'h0B, 8'h0C: c = CL_SPACE;
        8'h0A: c = CL_LF;
        8'h22: c = CL_QUOTE;
        default: c = CL_OTHER;
      endcase
    end
    return c;
  endfunction

  function automatic scan_t next_scan(scan_t prev, cls_t c);
    scan_t n;
    case (prev)
      SC_IDLE:      n = (c == CL_LT) ? SC_LT : SC_IDLE;
      SC_LT: begin
        case (c)
          CL_BANG:  n = SC_BANG;
          CL_SLASH: n = SC_CLOSE_NAME;
          CL_ALNUM: n = SC_OPEN_NAME;
          default:  n = SC_IDLE;
        endcase
      end
      SC_BANG:      n = (c == CL_DASH) ? SC_CMT : SC_IDLE;
      SC_CMT:       n = (c == CL_DASH) ? SC_CMT_DASH : SC_CMT;
      SC_CMT_DASH:  n = (c == CL_DASH) ? SC_CMT_DASH2 : SC_CMT;
      SC_CMT_DASH2: n = (c == CL_GT) ? SC_END : SC_CMT;
      SC_OPEN_NAME: begin
        case (c)
          CL_SLASH:          n = SC_SLASH;
          CL_GT:             n = SC_END;
          CL_SPACE, CL_LF:   n = SC_ATTR;
          CL_QUOTE:          n = SC_IDLE;
          default:           n = SC_OPEN_NAME;
        endcase
      end
      SC_ATTR: begin
        case (c)
          CL_SLASH: n = SC_SLASH;
          CL_GT:    n = SC_END;
          default:  n = SC_ATTR;
        endcase
      end
      SC_SLASH:     n = (c == CL_GT) ? SC_END : SC_ATTR;
      SC_CLOSE_NAME: begin
        case (c)
          CL_GT:    n = SC_END;
          CL_ALNUM: n = SC_CLOSE_NAME;
          default:  n = SC_IDLE;
        endcase
      end
      default:      n = (c == CL_LT) ? SC_LT : SC_IDLE;
    endcase
    return n;
  endfunction

  // does character b at position pos match void name j
  function automatic logic void_char_hit(int j, logic [POS_W-1:0] pos, logic [7:0] b);
    int  k;
    logic hit;
    k   = VOID_OFF[j] + int'(pos);
    hit = 1'b0;
    if (int'(pos) < VOID_LEN[j]) begin
      hit = (VOID_TEXT[(VOID_CHARS - 1 - k) * 8 +: 8] == b);
    end
    return hit;
  endfunction

endpackage

@@ rtl/core/htet_in_if.sv @@
// htet_in_if: byte input channel of the tag tokenizer
// depends on htet_pkg
`timescale 1ns / 1ps

interface htet_in_if;
  import htet_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

@@ rtl/core/htet_out_if.sv @@
// htet_out_if: event result channel of the tag tokenizer
// depends on htet_pkg
`timescale 1ns / 1ps

interface htet_out_if;
  import htet_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] event_kind;
  logic [BYTE_W-1:0] name_char;
  logic [LEN_W-1:0]  name_length;
  logic              name_truncated;
  logic              last_of_run;

  modport source (output valid, output event_kind, output name_char, output name_length,
                  output name_truncated, output last_of_run, input ready);
  modport sink   (input valid, input event_kind, input name_char, input name_length,
                  input name_truncated, input last_of_run, output ready);
endinterface

@@ rtl/core/htet_ram.sv @@
// htet_ram: generic single write port, single read port ram with registered read
// depends on nothing
`timescale 1ns / 1ps

module htet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/htet_ctrl.sv @@
// htet_ctrl: handshake controller of the tag tokenizer
// depends on htet_pkg
`timescale 1ns / 1ps

module htet_ctrl
  import htet_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  htet_stat_t stat,
  output htet_cmd_t  cmd
);

  ctl_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      C_IDLE: begin
        if (in_valid) begin
          if (stat.ev_stream) begin
            state_next = C_READ;
          end else if (stat.ev_single) begin
            state_next = C_EMIT;
          end
        end
      end
      C_READ: state_next = C_EMIT;
      C_EMIT: begin
        if (out_ready) begin
          state_next = stat.last ? C_IDLE : C_READ;
        end
      end
      default: state_next = C_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd.step    = 1'b0;
    cmd.advance = 1'b0;
    case (state)
      C_IDLE: begin
        in_ready = 1'b1;
        cmd.step = in_valid;
      end
      C_EMIT: begin
        out_valid   = 1'b1;
        cmd.advance = out_ready && !stat.last;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/core/htet_dpath.sv @@
// htet_dpath: scanner state, name capture, void match and result registers
// depends on htet_pkg and htet_ram
`timescale 1ns / 1ps

module htet_dpath
  import htet_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  htet_cmd_t         cmd,
  output htet_stat_t        stat,
  input  logic [BYTE_W-1:0] data_byte,
  output logic [KIND_W-1:0] event_kind,
  output logic [BYTE_W-1:0] name_char,
  output logic [LEN_W-1:0]  name_length,
  output logic              name_truncated,
  output logic              last_of_run
);

  scan_t               scan_state;
  logic [CNT_W-1:0]    name_count;
  logic                overflow_seen;
  logic [VOID_NUM-1:0] cand;

  kind_t               em_kind;
  logic [CNT_W-1:0]    em_len;
  logic                em_trunc;
  logic                em_zero;
  logic [ADDR_W-1:0]   rd_idx;
  logic [BYTE_W-1:0]   rdata;

  scan_t               prev, cur;
  logic                capture, has_room, is_void, has_event, is_comment;
  kind_t               ev_kind;
  logic [POS_W-1:0]    pos;
  logic [VOID_NUM-1:0] cand_next, len_hit;

  always_comb begin
    prev     = (scan_state > SC_CLOSE_NAME) ? SC_IDLE : scan_state;
    cur      = next_scan(prev, byte_class(data_byte));
    capture  = (cur == SC_OPEN_NAME && (prev == SC_LT || prev == SC_OPEN_NAME)) ||
               (cur == SC_CLOSE_NAME && prev == SC_CLOSE_NAME);
    has_room = name_count < CNT_W'(NAME_DEPTH);
    pos      = (name_count > CNT_W'(VOID_MAX)) ? POS_W'(VOID_MAX + 1) : name_count[POS_W-1:0];
    for (int j = 0; j < VOID_NUM; j++) begin
      cand_next[j] = cand[j] && void_char_hit(j, pos, data_byte);
      len_hit[j]   = cand[j] && (name_count == CNT_W'(VOID_LEN[j]));
    end
    is_void = !overflow_seen && (|len_hit);

    has_event = 1'b0;
    ev_kind   = EV_CMT_START;
    if (prev == SC_BANG && cur == SC_CMT) begin
      has_event = 1'b1;
    end else if (cur == SC_END) begin
      has_event = 1'b1;
      case (prev)
        SC_CMT_DASH2:          ev_kind = EV_CMT_END;
        SC_OPEN_NAME, SC_ATTR: ev_kind = is_void ? EV_SELF : EV_OPEN;
        SC_CLOSE_NAME:         ev_kind = EV_CLOSE;
        default:               ev_kind = EV_SELF;
      endcase
    end
    is_comment = (ev_kind == EV_CMT_START) || (ev_kind == EV_CMT_END);

    stat.ev_single = has_event && (is_comment || name_count == '0);
    stat.ev_stream = has_event && !is_comment && name_count != '0;
    stat.last      = em_zero || ((CNT_W'(rd_idx) + CNT_W'(1)) == em_len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state    <= SC_IDLE;
      name_count    <= '0;
      overflow_seen <= 1'b0;
      cand          <= '1;
    end else if (cmd.step) begin
      if (capture) begin
        if (has_room) begin
          name_count <= name_count + CNT_W'(1);
          cand       <= cand_next;
        end else begin
          overflow_seen <= 1'b1;
        end
      end
      // tag end or fall back to idle clears the name
      if (cur == SC_END || cur == SC_IDLE) begin
        scan_state    <= SC_IDLE;
        name_count    <= '0;
        overflow_seen <= 1'b0;
        cand          <= '1;
      end else begin
        scan_state <= cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && has_event) begin
      em_kind  <= ev_kind;
      em_zero  <= is_comment || name_count == '0;
      em_len   <= is_comment ? '0 : name_count;
      em_trunc <= is_comment ? 1'b0 : overflow_seen;
      rd_idx   <= '0;
    end else if (cmd.advance) begin
      rd_idx <= rd_idx + ADDR_W'(1);
    end
  end

  htet_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (NAME_DEPTH)
  ) u_name_ram (
    .clk   (clk),
    .we    (cmd.step && capture && has_room),
    .waddr (name_count[ADDR_W-1:0]),
    .wdata (data_byte),
    .raddr (rd_idx),
    .rdata (rdata)
  );

  assign event_kind     = em_kind;
  assign name_char      = em_zero ? '0 : rdata;
  assign name_length    = LEN_W'(em_len);
  assign name_truncated = em_trunc;
  assign last_of_run    = stat.last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    name_count <= CNT_W'(NAME_DEPTH))
    else $error("name count beyond store depth");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    overflow_seen |-> name_count == CNT_W'(NAME_DEPTH))
    else $error("overflow flagged with room left in the store");

  a_advance_step: assert property (@(posedge clk) disable iff (rst)
    cmd.advance && !cmd.step |=> rd_idx == $past(rd_idx) + ADDR_W'(1))
    else $error("read index did not step after a result was taken");

endmodule

@@ rtl/core/html_tag_event_tokenizer_core.sv @@
// html_tag_event_tokenizer_core: top level of the byte-serial tag tokenizer
// depends on htet_pkg, htet_in_if, htet_out_if, htet_ctrl, htet_dpath
`timescale 1ns / 1ps

// channel   dir   item contents
// in_ch     in    data_byte
// out_ch    out   event_kind, name_char, name_length, name_truncated, last_of_run
//
// a byte that raises no event leaves the controller idle; the next byte is taken the cycle after
// a comment event or a nameless tag event is accepted, then shows a single result
// a named tag event of n characters shows n results, one name ram read per result
// rst is synchronous and active high; it returns the scanner to idle and empties the name
// no byte is taken while an event's results are still on their way out; out_ch stalls
// hold the shown result and the read position

module html_tag_event_tokenizer_core
  import htet_pkg::*;
(
  input logic              clk,
  input logic              rst,
  htet_in_if.sink          in_ch,
  htet_out_if.source       out_ch
);

  htet_cmd_t  cmd;
  htet_stat_t stat;

  // controller: sequences accept, name read and result hand-off
  htet_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: byte classing, scanner, name store and the result registers
  htet_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .data_byte      (in_ch.data_byte),
    .event_kind     (out_ch.event_kind),
    .name_char      (out_ch.name_char),
    .name_length    (out_ch.name_length),
    .name_truncated (out_ch.name_truncated),
    .last_of_run    (out_ch.last_of_run)
  );

endmodule

@@ verif/html_tag_event_tokenizer_core_tb.sv @@
// html_tag_event_tokenizer_core_tb: self-checking bench for the byte-serial tag tokenizer
// predicts each event run from the accepted bytes; needs htet_pkg, htet_in_if, htet_out_if and the core
`timescale 1ns / 1ps

module html_tag_event_tokenizer_core_tb;
  import htet_pkg::*;

  // the watchdog limit QUIET_LIMIT sits well above the long receiver hold-off HOLD_CYCLES
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_BYTES = 52;
  localparam int HOLD_CYCLES = 300;

  // traffic shapes of the random part, one after another
  typedef enum int {
    PACE_STEADY,
    PACE_SEND_GAPS,
    PACE_RECV_STALLS,
    PACE_MIXED
  } pace_t;

  // one result of an event run, laid out like the output item
  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] ch;
    logic [LEN_W-1:0]  len;
    logic              trunc;
    logic              last;
  } event_rec_t;

  // tag scanner of our own, plus the queue of event results it has predicted
  class tag_event_scoreboard;
    cls_t       cls_lut[256];
    string      void_tags[15];
    scan_t      scan_q;
    logic [7:0] name_buf[NAME_DEPTH];
    int         name_cnt;
    bit         name_over;
    event_rec_t pending_events[$];
    int         fail_count;

    function new();
      int i;
      void_tags = '{"area", "base", "br", "col", "embed", "hr", "img", "input",
                    "keygen", "link", "meta", "param", "source", "track", "wbr"};
      for (i = 0; i < 256; i++) begin
        if ((i >= 8'h30 && i <= 8'h39) || (i >= 8'h41 && i <= 8'h5A) ||
            (i >= 8'h61 && i <= 8'h7A)) begin
          cls_lut[i] = CL_ALNUM;
        end else begin
          cls_lut[i] = CL_OTHER;
        end
      end
      cls_lut[8'h3C] = CL_LT;     // <
      cls_lut[8'h21] = CL_BANG;   // !
      cls_lut[8'h2D] = CL_DASH;   // -
      cls_lut[8'h2F] = CL_SLASH;  // /
      cls_lut[8'h3E] = CL_GT;     // >
      cls_lut[8'h20] = CL_SPACE;
      cls_lut[8'h09] = CL_SPACE;
      cls_lut[8'h0D] = CL_SPACE;
      cls_lut[8'h0B] = CL_SPACE;
      cls_lut[8'h0C] = CL_SPACE;
      cls_lut[8'h0A] = CL_LF;
      cls_lut[8'h22] = CL_QUOTE;  // double quote
      scan_q     = SC_IDLE;
      name_cnt   = 0;
      name_over  = 1'b0;
      fail_count = 0;
    endfunction

    function scan_t scan_next(scan_t s, cls_t c);
      scan_t n;
      n = SC_IDLE;
      case (s)
        SC_IDLE:      if (c == CL_LT) n = SC_LT;
        SC_LT: begin
          if (c == CL_BANG) n = SC_BANG;
          else if (c == CL_SLASH) n = SC_CLOSE_NAME;
          else if (c == CL_ALNUM) n = SC_OPEN_NAME;
        end
        SC_BANG:      if (c == CL_DASH) n = SC_CMT;
        SC_CMT:       n = (c == CL_DASH) ? SC_CMT_DASH : SC_CMT;
        SC_CMT_DASH:  n = (c == CL_DASH) ? SC_CMT_DASH2 : SC_CMT;
        SC_CMT_DASH2: n = (c == CL_GT) ? SC_END : SC_CMT;
        SC_OPEN_NAME: begin
          if (c == CL_SLASH) n = SC_SLASH;
          else if (c == CL_GT) n = SC_END;
          else if (c == CL_SPACE || c == CL_LF) n = SC_ATTR;
          else if (c != CL_QUOTE) n = SC_OPEN_NAME;
        end
        SC_ATTR: begin
          if (c == CL_SLASH) n = SC_SLASH;
          else if (c == CL_GT) n = SC_END;
          else n = SC_ATTR;
        end
        SC_SLASH:     n = (c == CL_GT) ? SC_END : SC_ATTR;
        SC_CLOSE_NAME: begin
          if (c == CL_GT) n = SC_END;
          else if (c == CL_ALNUM) n = SC_CLOSE_NAME;
        end
        default:      n = SC_IDLE;
      endcase
      return n;
    endfunction

    // exact, case-sensitive match against the void list; a clipped name never matches
    function bit name_is_void();
      int  v;
      int  i;
      bit  hit;
      bit  same;
      hit = 1'b0;
      if (!name_over) begin
        for (v = 0; v < 15; v++) begin
          if (void_tags[v].len() == name_cnt) begin
            same = 1'b1;
            for (i = 0; i < name_cnt; i++) begin
              if (name_buf[i] != void_tags[v][i]) same = 1'b0;
            end
            if (same) hit = 1'b1;
          end
        end
      end
      return hit;
    endfunction

    function void note_fail(string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
    endfunction

    // one accepted byte: advance the scanner and queue whatever run it ends
    function void take_byte(logic [7:0] b);
      scan_t was;
      scan_t now;
      kind_t ev;
      bit    fires;
      int    i;
      was = scan_q;
      now = scan_next(was, cls_lut[b]);

      // name capture: first letter or digit after '<', later opening-name bytes, closing-name letters and digits
      if ((now == SC_OPEN_NAME && (was == SC_LT || was == SC_OPEN_NAME)) ||
          (now == SC_CLOSE_NAME && was == SC_CLOSE_NAME)) begin
        if (name_cnt < NAME_DEPTH) begin
          name_buf[name_cnt] = b;
          name_cnt++;
        end else begin
          name_over = 1'b1;
        end
      end

      fires = 1'b1;
      ev    = EV_OPEN;
      if (was == SC_BANG && now == SC_CMT) begin
        ev = EV_CMT_START;
      end else if (now != SC_END) begin
        fires = 1'b0;
      end else begin
        case (was)
          SC_CMT_DASH2:          ev = EV_CMT_END;
          SC_OPEN_NAME, SC_ATTR: ev = name_is_void() ? EV_SELF : EV_OPEN;
          SC_SLASH:              ev = EV_SELF;
          SC_CLOSE_NAME:         ev = EV_CLOSE;
          default:               fires = 1'b0;
        endcase
      end

      if (fires) begin
        if (ev == EV_CMT_START || ev == EV_CMT_END) begin
          pending_events.push_back('{ev, 8'h00, '0, 1'b0, 1'b1});
        end else if (name_cnt == 0) begin
          pending_events.push_back('{ev, 8'h00, '0, name_over, 1'b1});
        end else begin
          for (i = 0; i < name_cnt; i++) begin
            pending_events.push_back('{ev, name_buf[i], LEN_W'(name_cnt), name_over,
                                       (i == name_cnt - 1)});
          end
        end
      end

      // a finished or abandoned tag drops the name
      if (now == SC_END || now == SC_IDLE) begin
        scan_q    = SC_IDLE;
        name_cnt  = 0;
        name_over = 1'b0;
      end else begin
        scan_q = now;
      end
    endfunction

    function void check_event(event_rec_t got);
      event_rec_t want;
      if (pending_events.size() == 0) begin
        note_fail($sformatf("unexpected result: kind %0d char %02h len %0d trunc %0b last %0b",
                            got.kind, got.ch, got.len, got.trunc, got.last));
      end else begin
        want = pending_events.pop_front();
        if (got.kind !== want.kind || got.ch !== want.ch || got.len !== want.len ||
            got.trunc !== want.trunc || got.last !== want.last) begin
          note_fail($sformatf({"mismatch: expected kind %0d char %02h len %0d trunc %0b ",
                               "last %0b, got kind %0d char %02h len %0d trunc %0b last %0b"},
                              want.kind, want.ch, want.len, want.trunc, want.last,
                              got.kind, got.ch, got.len, got.trunc, got.last));
        end
      end
    endfunction

    function void close_out();
      if (pending_events.size() != 0) begin
        note_fail($sformatf("%0d expected results never arrived", pending_events.size()));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  htet_in_if  in_ch ();
  htet_out_if out_ch ();

  html_tag_event_tokenizer_core u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tag_event_scoreboard board;
  logic [7:0]          burst[$];   // bytes waiting to be offered
  int                  send_idle_pct  = 0;
  int                  recv_stall_pct = 0;
  int                  hold_req       = 0;
  int                  hold_left      = 0;
  int                  quiet_cycles   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // both channels are sampled here, input first, so a byte is predicted before any
  // result it may cause; the watchdog counts edges with nothing accepted on either side
  always @(posedge clk) begin : watch_side
    bit moved;
    moved = 1'b0;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        board.take_byte(in_ch.data_byte);
        moved = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        board.check_event('{kind_t'(out_ch.event_kind), out_ch.name_char, out_ch.name_length,
                            out_ch.name_truncated, out_ch.last_of_run});
        moved = 1'b1;
      end
      if (moved) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // receiver: a requested hold-off wins, otherwise random stalls at the current rate
  always @(posedge clk) begin : recv_side
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // offer one byte, with random idle cycles in front of it, and wait for the handshake
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_burst();
    foreach (burst[i]) send_byte(burst[i]);
    burst.delete();
  endtask

  // sender stops until every predicted result has come back
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) burst.push_back(s[i]);
  endfunction

  function automatic logic [7:0] rand_alnum();
    logic [7:0] b;
    case ($urandom_range(0, 2))
      0:       b = 8'h30 + 8'($urandom_range(0, 9));
      1:       b = 8'h41 + 8'($urandom_range(0, 25));
      default: b = 8'h61 + 8'($urandom_range(0, 25));
    endcase
    return b;
  endfunction

  // bytes that steer the scanner
  function automatic logic [7:0] rand_special();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0:       b = 8'h3C;
      1:       b = 8'h21;
      2:       b = 8'h2D;
      3:       b = 8'h2F;
      4:       b = 8'h3E;
      5:       b = 8'h22;
      6:       b = 8'h0A;
      default: b = 8'h20;
    endcase
    return b;
  endfunction

  // any byte that keeps an opening name going, mostly letters and digits
  function automatic logic [7:0] rand_name_byte();
    logic [7:0] b;
    if ($urandom_range(0, 99) < 80) begin
      b = rand_alnum();
    end else begin
      b = 8'($urandom_range(0, 255));
      while (b inside {8'h2F, 8'h3E, 8'h20, 8'h09, 8'h0D, 8'h0B, 8'h0C, 8'h0A, 8'h22}) begin
        b = 8'($urandom_range(0, 255));
      end
    end
    return b;
  endfunction

  // attribute text: anything but a slash or a closing bracket
  function automatic logic [7:0] rand_attr_byte();
    logic [7:0] b;
    if ($urandom_range(0, 99) < 40) begin
      b = rand_alnum();
    end else begin
      b = 8'($urandom_range(0, 255));
      while (b == 8'h2F || b == 8'h3E) b = 8'($urandom_range(0, 255));
    end
    return b;
  endfunction

  // one random stretch of text; counted is low for bytes the scanner mostly ignores
  function automatic void build_burst(output bit counted);
    int         sel;
    int         n;
    int         i;
    logic [7:0] b;
    string      tag;
    counted = 1'b1;
    sel     = $urandom_range(0, 99);
    if (sel < 15) begin
      // comment with a dash-heavy body, now and then left open
      add_text("<!-");
      n = $urandom_range(0, 6);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 99) < 35) b = 8'h2D;
        else if ($urandom_range(0, 9) == 0) b = 8'h3E;
        else b = 8'($urandom_range(0, 255));
        burst.push_back(b);
      end
      if ($urandom_range(0, 9) != 0) add_text("-->");
    end else if (sel < 50) begin
      // opening tag: void names with and without a twist, long names around the store depth
      burst.push_back(8'h3C);
      n = $urandom_range(0, 99);
      if (n < 20) begin
        tag = board.void_tags[$urandom_range(0, 14)];
        case ($urandom_range(0, 7))
          0:       tag[0] = tag[0] - 8'd32;
          1:       tag = tag.substr(0, tag.len() - 2);
          2:       tag = {tag, "x"};
          default: ;
        endcase
        add_text(tag);
      end else if (n < 26) begin
        if ($urandom_range(0, 1) == 0) add_text(board.void_tags[$urandom_range(0, 14)]);
        else burst.push_back(rand_alnum());
        n = $urandom_range(31, 40);
        while (burst.size() < n + 1) burst.push_back(rand_name_byte());
      end else begin
        burst.push_back(rand_alnum());
        n = $urandom_range(0, 7);
        for (i = 0; i < n; i++) burst.push_back(rand_name_byte());
      end
      if ($urandom_range(0, 19) == 0) begin
        burst.push_back(8'h22);  // quote straight after the name drops the tag
      end else begin
        if ($urandom_range(0, 99) < 40) begin
          burst.push_back($urandom_range(0, 1) ? 8'h20 : 8'h0A);
          n = $urandom_range(0, 8);
          for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
              burst.push_back(8'h2F);
              burst.push_back(rand_alnum());
            end else begin
              burst.push_back(rand_attr_byte());
            end
          end
        end
        n = $urandom_range(0, 19);
        if (n < 14) add_text(">");
        else if (n < 19) add_text("/>");
      end
    end else if (sel < 75) begin
      // closing tag, empty and long names included, now and then broken off
      add_text("</");
      n = $urandom_range(0, 99);
      if (n < 10) n = 0;
      else if (n < 14) n = $urandom_range(31, 40);
      else n = $urandom_range(1, 8);
      for (i = 0; i < n; i++) burst.push_back(rand_alnum());
      if ($urandom_range(0, 19) == 0) burst.push_back(rand_special());
      add_text(">");
    end else if (sel < 88) begin
      counted = 1'b0;
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) burst.push_back(8'($urandom_range(0, 255)));
    end else begin
      counted = 1'b0;
      n = $urandom_range(1, 8);
      for (i = 0; i < n; i++) begin
        burst.push_back($urandom_range(0, 1) ? rand_special() : 8'($urandom_range(0, 255)));
      end
    end
  endfunction

  initial begin : stimulus
    pace_t pace;
    int    sent;
    bit    counted;
    bit    paused;

    board           = new();
    rst             = 1'b1;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: comment, void open, empty close, explicit self-close, named close,
    // name holding the byte extremes, and a tag abandoned by a quote
    add_text("<!--->");
    add_text("<br>");
    add_text("</>");
    add_text("<a/>");
    add_text("</b>");
    add_text("<p");
    burst.push_back(8'hFF);
    burst.push_back(8'h00);
    add_text(">");
    add_text("<a\"");
    send_burst();

    // a void name run past the store depth is clipped and no longer void
    add_text("<input");
    repeat (30) burst.push_back(rand_alnum());
    add_text(">");
    send_burst();
    settle();

    for (int p = 0; p < 4; p++) begin
      pace = pace_t'(p);
      case (pace)
        PACE_STEADY: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_req       = HOLD_CYCLES;  // receiver goes quiet while bytes keep coming
        end
        PACE_SEND_GAPS: begin
          send_idle_pct  = 72;
          recv_stall_pct = 0;
        end
        PACE_RECV_STALLS: begin
          send_idle_pct  = 0;
          recv_stall_pct = 72;
        end
        default: begin
          send_idle_pct  = 9;
          recv_stall_pct = 9;
        end
      endcase
      sent   = 0;
      paused = 1'b0;
      while (sent < PHASE_BYTES) begin
        build_burst(counted);
        if (counted) sent += burst.size();
        send_burst();
        // mid-phase pause with everything drained
        if (pace == PACE_RECV_STALLS && !paused && sent >= PHASE_BYTES / 2) begin
          settle();
          paused = 1'b1;
        end
      end
      settle();
    end

    repeat (16) @(posedge clk);
    board.close_out();
    if (board.fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
